// File: sv/rtpc_pkg.sv
// ----------------------------------------------------------------------------
// rtpc_pkg
// Types, constants and helpers shared by the range-to-prefix cover block.
// ----------------------------------------------------------------------------
package rtpc_pkg;

   localparam int VALUE_BITS = 32;
   localparam int DATA_W     = 32;
   localparam int LEN_W      = 6;
   localparam int CNT_W      = 6;
   localparam int MAX_OUT    = 62;

   localparam logic [DATA_W-1:0] VALUE_MASK = DATA_W'((64'd1 << VALUE_BITS) - 64'd1);
   localparam logic [CNT_W-1:0]  CNT_CAP    = CNT_W'(MAX_OUT - 1);

   typedef struct packed {
      logic [DATA_W-1:0] range_low;
      logic [DATA_W-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] prefix_value;
      logic [LEN_W-1:0]  prefix_length;
      logic              is_final;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UP,
      ST_DOWN,
      ST_MID
   } state_type;

   typedef struct packed {
      logic              emit;
      logic              advance;
      logic [DATA_W-1:0] lo_next;
      logic [DATA_W-1:0] hi_next;
      rsp_type           rsp;
   } step_type;

   // VALUE_BITS minus the bit length of a block mask
   function automatic logic [LEN_W-1:0] prefix_len(input logic [DATA_W-1:0] blk);
      logic [DATA_W-1:0] v;
      logic [LEN_W-1:0]  bl;
      v  = blk & VALUE_MASK;
      bl = '0;
      if (v[31:16] != 16'd0) begin
         bl = bl + LEN_W'(16);
         v  = v >> 16;
      end
      if (v[15:8] != 8'd0) begin
         bl = bl + LEN_W'(8);
         v  = v >> 8;
      end
      if (v[7:4] != 4'd0) begin
         bl = bl + LEN_W'(4);
         v  = v >> 4;
      end
      if (v[3:2] != 2'd0) begin
         bl = bl + LEN_W'(2);
         v  = v >> 2;
      end
      if (v[1]) begin
         bl = bl + LEN_W'(1);
         v  = v >> 1;
      end
      if (v[0]) begin
         bl = bl + LEN_W'(1);
      end
      return LEN_W'(VALUE_BITS) - bl;
   endfunction

endpackage

// File: sv/rtpc_step.sv
// ----------------------------------------------------------------------------
// rtpc_step
// Shared step unit: block mask, edge compare, next edge and prefix length
// for the current phase of one range.
// ----------------------------------------------------------------------------
module rtpc_step (
   input  rtpc_pkg::state_type             state,
   input  logic [rtpc_pkg::DATA_W-1:0]     lo,
   input  logic [rtpc_pkg::DATA_W-1:0]     hi,
   input  logic [rtpc_pkg::CNT_W-1:0]      cnt,
   output rtpc_pkg::step_type              step
);

   logic [rtpc_pkg::DATA_W-1:0] lo_m1;
   logic [rtpc_pkg::DATA_W-1:0] blk_up;
   logic [rtpc_pkg::DATA_W-1:0] top_up;
   logic [rtpc_pkg::DATA_W-1:0] hi_p1;
   logic [rtpc_pkg::DATA_W-1:0] blk_dn;
   logic [rtpc_pkg::DATA_W-1:0] hi_clr;
   logic [rtpc_pkg::DATA_W-1:0] span;
   logic [rtpc_pkg::DATA_W-1:0] len_src;
   logic                        up_stop;
   logic                        dn_stop;
   logic                        cap;

   always_comb begin
      lo_m1   = (lo - 1'b1) & rtpc_pkg::VALUE_MASK;
      blk_up  = (lo ^ lo_m1) & ~lo & rtpc_pkg::VALUE_MASK;
      top_up  = lo | blk_up;
      up_stop = (top_up >= hi);
      hi_p1   = (hi + 1'b1) & rtpc_pkg::VALUE_MASK;
      blk_dn  = (hi_p1 ^ hi) & hi;
      hi_clr  = hi & ~blk_dn;
      dn_stop = (lo >= hi_clr);
      span    = (hi - lo) & rtpc_pkg::VALUE_MASK;
      cap     = (cnt >= rtpc_pkg::CNT_CAP);

      step                   = '0;
      step.lo_next           = lo;
      step.hi_next           = hi;
      len_src                = span;
      unique case (state)
         rtpc_pkg::ST_UP: begin
            len_src                = blk_up;
            step.rsp.prefix_value  = lo;
            if (up_stop || cap) begin
               step.advance = 1'b1;
            end else begin
               step.emit    = 1'b1;
               step.lo_next = (top_up + 1'b1) & rtpc_pkg::VALUE_MASK;
            end
         end
         rtpc_pkg::ST_DOWN: begin
            len_src                = blk_dn;
            step.rsp.prefix_value  = hi_clr;
            if (dn_stop || cap) begin
               step.advance = 1'b1;
            end else begin
               step.emit    = 1'b1;
               step.hi_next = (hi_clr - 1'b1) & rtpc_pkg::VALUE_MASK;
            end
         end
         rtpc_pkg::ST_MID: begin
            len_src               = span;
            step.rsp.prefix_value = lo;
            step.rsp.is_final     = 1'b1;
            step.emit             = 1'b1;
            step.advance          = 1'b1;
         end
         default: begin
            len_src = span;
         end
      endcase
      step.rsp.prefix_length = rtpc_pkg::prefix_len(len_src);
   end

endmodule

// File: sv/rtpc_seq.sv
// ----------------------------------------------------------------------------
// rtpc_seq
// Phase sequencer: holds the working edges and result count of one range
// and steps the shared unit once per cycle unless a result waits for a busy result slot.
// ----------------------------------------------------------------------------
module rtpc_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  rtpc_pkg::req_type       req_data,
   input  logic                    slot_free,
   output logic                    busy,
   output logic                    emit,
   output rtpc_pkg::rsp_type       emit_data
);

   rtpc_pkg::state_type          state_ff;
   rtpc_pkg::state_type          state_in;
   logic [rtpc_pkg::DATA_W-1:0]  lo_ff;
   logic [rtpc_pkg::DATA_W-1:0]  lo_in;
   logic [rtpc_pkg::DATA_W-1:0]  hi_ff;
   logic [rtpc_pkg::DATA_W-1:0]  hi_in;
   logic [rtpc_pkg::CNT_W-1:0]   cnt_ff;
   logic [rtpc_pkg::CNT_W-1:0]   cnt_in;
   rtpc_pkg::step_type           step;
   logic                         go;
   logic [rtpc_pkg::DATA_W-1:0]  req_lo;
   logic [rtpc_pkg::DATA_W-1:0]  req_hi;

   rtpc_step u_step (
      .state (state_ff),
      .lo    (lo_ff),
      .hi    (hi_ff),
      .cnt   (cnt_ff),
      .step  (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      req_lo    = req_data.range_low  & rtpc_pkg::VALUE_MASK;
      req_hi    = req_data.range_high & rtpc_pkg::VALUE_MASK;
      go        = !step.emit || slot_free;
      busy      = (state_ff != rtpc_pkg::ST_IDLE);
      emit      = step.emit && slot_free;
      emit_data = step.rsp;
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         rtpc_pkg::ST_IDLE: begin
            if (req_fire) begin
               lo_in  = req_lo;
               hi_in  = req_hi;
               cnt_in = '0;
               state_in = (req_lo > req_hi) ? rtpc_pkg::ST_IDLE : rtpc_pkg::ST_UP;
            end
         end
         rtpc_pkg::ST_UP, rtpc_pkg::ST_DOWN, rtpc_pkg::ST_MID: begin
            if (go) begin
               lo_in = step.lo_next;
               hi_in = step.hi_next;
               if (step.emit) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (step.advance) begin
                  unique case (state_ff)
                     rtpc_pkg::ST_UP:   state_in = rtpc_pkg::ST_DOWN;
                     rtpc_pkg::ST_DOWN: state_in = rtpc_pkg::ST_MID;
                     default:           state_in = rtpc_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         default: begin
            state_in = rtpc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/range_to_prefix_cover_unit.sv
// ----------------------------------------------------------------------------
// range_to_prefix_cover_unit
// Splits one inclusive range into aligned prefixes: blocks grown up from
// the low edge, blocks peeled down from the high edge, then the middle block.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | handshake
//  req     | in        | range_low, range_high                    | valid / stall
//  rsp     | out       | prefix_value, prefix_length, is_final    | valid / stall
//
//  One range is accepted, then stepped through its prefixes, with a step
//  that gives no prefix at each of the two phase changes, up to 62 prefixes;
//  the single step unit gives at most one prefix per cycle.
//  An inverted range is accepted and yields no item.
//  Reset clears the sequencer state and the output valid.
//  A stalled output register holds its item and stops the sequencer at its next prefix.
// ----------------------------------------------------------------------------
module range_to_prefix_cover_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtpc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rtpc_pkg::rsp_type    rsp_data
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rtpc_pkg::rsp_type    rsp_data_ff;
   rtpc_pkg::rsp_type    rsp_data_in;
   logic                 slot_free;
   logic                 busy;
   logic                 emit;
   rtpc_pkg::rsp_type    emit_data;

   rtpc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_valid && !req_stall),
      .req_data  (req_data),
      .slot_free (slot_free),
      .busy      (busy),
      .emit      (emit),
      .emit_data (emit_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      slot_free    = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      ((req_data.range_low & rtpc_pkg::VALUE_MASK) <=
       (req_data.range_high & rtpc_pkg::VALUE_MASK)) |=> req_stall)
      else $error("accepted range did not start the sequencer");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.prefix_length <= rtpc_pkg::LEN_W'(rtpc_pkg::VALUE_BITS))
      else $error("prefix length beyond value width");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((64'(rsp_data.prefix_value) &
         ((64'd1 << (rtpc_pkg::LEN_W'(rtpc_pkg::VALUE_BITS) - rsp_data.prefix_length))
          - 64'd1)) == 64'd0))
      else $error("prefix value has bits set below its prefix");
`endif

endmodule
